[sv/rrb_pkg.sv]
// Package: shared constants and types of the response reorder buffer.
package rrb_pkg;

	localparam int WINDOW      = 16;
	localparam int MAX_RESULTS = 16;
	localparam int ID_W        = 16;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = $clog2(WINDOW);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ID_W-1:0]  id_t;
	typedef logic [DATA_W-1:0] data_t;

	// Access requests from the control logic to the slot store.
	typedef struct packed {
		logic wr_en;
		idx_t wr_idx;
		logic rd_en;
		idx_t rd_idx;
	} slot_ctl_t;

endpackage

[sv/response_reorder_buffer.sv]
// Top level: in-order release of out-of-order tagged completions.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, seq_id, payload,      | to block
//          | payload_ok                                |
//  out     | out_valid, out_ready, out_seq_id,         | from block
//          | out_payload, last                         |
//
// Flow: an input item is accepted in idle and parked in the slot memory;
//   the drain then releases one item per memory read until the next slot
//   is empty or the per-item limit is reached, or finds nothing to release.
// The single read port of the payload memory sets the drain rate.
// Reset: full bits cleared, expected id = 1, head slot = 1 mod WINDOW.
// Stalls: a held result stays in the output register; the next input item
//   is still accepted meanwhile, and a drain waits for the register to free.
module response_reorder_buffer (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] seq_id,
	input  logic [31:0] payload,
	input  logic        payload_ok,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_seq_id,
	output logic [31:0] out_payload,
	output logic        last
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic               state_q;
	rrb_pkg::id_t       expected_q;
	rrb_pkg::idx_t      head_q;
	rrb_pkg::cnt_t      cnt_q;
	logic               out_valid_q;
	rrb_pkg::id_t       out_seq_id_q;
	logic               last_q;

	rrb_pkg::slot_ctl_t ctl;
	rrb_pkg::data_t     rd_data;
	logic [rrb_pkg::WINDOW-1:0] full;

	logic               accept;
	rrb_pkg::id_t       ahead;
	logic               in_window;
	logic [rrb_pkg::IDX_W:0] idx_sum;
	rrb_pkg::idx_t      wr_idx;
	rrb_pkg::idx_t      head_nx;
	rrb_pkg::cnt_t      cnt_nx;
	logic               issue;
	logic               last_nx;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// distance ahead of the expected id, modulo 2^16
	assign ahead     = seq_id - expected_q;
	assign in_window = (ahead < rrb_pkg::ID_W'(rrb_pkg::WINDOW));

	// slot = (head + ahead) mod WINDOW; ahead < WINDOW so one subtract fixes it
	always_comb begin
		idx_sum = {1'b0, head_q} + (rrb_pkg::IDX_W + 1)'(ahead[rrb_pkg::IDX_W-1:0]);
		if (idx_sum >= (rrb_pkg::IDX_W + 1)'(rrb_pkg::WINDOW)) begin
			idx_sum = idx_sum - (rrb_pkg::IDX_W + 1)'(rrb_pkg::WINDOW);
		end
		wr_idx = idx_sum[rrb_pkg::IDX_W-1:0];
	end

	assign head_nx = (head_q == rrb_pkg::IDX_W'(rrb_pkg::WINDOW - 1)) ?
		'0 : head_q + 1'b1;
	assign cnt_nx  = cnt_q + 1'b1;

	// release the head slot when it is parked and the output register frees
	assign issue = (state_q == ST_DRAIN) && full[head_q] &&
		(!out_valid_q || out_ready);

	// no slot is parked during a drain, so look one slot ahead
	assign last_nx = (cnt_nx == rrb_pkg::CNT_W'(rrb_pkg::MAX_RESULTS)) ||
		!full[head_nx];

	// park only valid, in-window, not-yet-parked completions
	always_comb begin
		ctl.wr_en  = accept && payload_ok && in_window && !full[wr_idx];
		ctl.wr_idx = wr_idx;
		ctl.rd_en  = issue;
		ctl.rd_idx = head_q;
	end

	rrb_slots u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_data (payload),
		.rd_data (rd_data),
		.full    (full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			expected_q  <= rrb_pkg::ID_W'(1);
			head_q      <= rrb_pkg::IDX_W'(1 % rrb_pkg::WINDOW);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end
				end
				ST_DRAIN: begin
					if (!full[head_q]) begin
						// nothing released by this item
						state_q <= ST_IDLE;
					end else if (issue) begin
						expected_q <= expected_q + 1'b1;
						head_q     <= head_nx;
						cnt_q      <= cnt_nx;
						if (last_nx) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output fields; payload comes straight from the memory read register
	always_ff @(posedge clk) begin
		if (issue) begin
			out_seq_id_q <= expected_q;
			last_q       <= last_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_seq_id  = out_seq_id_q;
	assign out_payload = rd_data;
	assign last        = last_q;

	// a release only ever reads a parked slot
	a_read_parked: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> full[ctl.rd_idx])
		else $error("release of an empty slot");

	// a release shows up next cycle carrying the id it was issued for
	a_release_id: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (out_valid && out_seq_id == $past(expected_q)))
		else $error("released id mismatch");

	// ids move only on a release
	a_expected_step: assert property (@(posedge clk) disable iff (!arst_n)
		!issue |=> $stable(expected_q))
		else $error("expected id moved without a release");

	// drain count stays within the per-item limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rrb_pkg::CNT_W'(rrb_pkg::MAX_RESULTS))
		else $error("drain count overflow");

endmodule

[sv/rrb_slots.sv]
// Slot store: payload memory with registered read, plus per-slot full bits.
module rrb_slots (
	input  logic                clk,
	input  logic                arst_n,
	input  rrb_pkg::slot_ctl_t  ctl,
	input  rrb_pkg::data_t      wr_data,
	output rrb_pkg::data_t      rd_data,
	output logic [rrb_pkg::WINDOW-1:0] full
);

	rrb_pkg::data_t mem_q [rrb_pkg::WINDOW];
	rrb_pkg::data_t rd_data_q;
	logic [rrb_pkg::WINDOW-1:0] full_q;

	// payload memory: one write and one read port, read data registered
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_idx] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[ctl.rd_idx];
		end
	end

	// full bits: set on park, cleared on release (never both in one cycle)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else begin
			if (ctl.wr_en) begin
				full_q[ctl.wr_idx] <= 1'b1;
			end
			if (ctl.rd_en) begin
				full_q[ctl.rd_idx] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign full    = full_q;

endmodule
